// ===== rtl/rmvf_pkg.sv =====
// Shared constants for the radial motion vector filter.
package rmvf_pkg;

  // Default coordinate format, unsigned Q12.4
  localparam int COORD_INT_BITS_DEF  = 12;
  localparam int COORD_FRAC_BITS_DEF = 4;

  // Register widths
  localparam int CENTER_W   = 12;
  localparam int SLOPE_W    = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;

  // Register reset values
  localparam logic [CENTER_W-1:0] CENTER_X_RST  = 12'd640;
  localparam logic [CENTER_W-1:0] CENTER_Y_RST  = 12'd360;
  localparam logic [SLOPE_W-1:0]  MIN_SLOPE_RST = 16'd11556;  // tan(10 deg) in Q0.16

  // Register indexes (byte address / 4)
  localparam logic [REG_IDX_W-1:0] REG_CENTER_X  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Y  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MIN_SLOPE = 2'd2;

endpackage

// ===== rtl/radial_motion_vector_filter.sv =====
// Top level of the radial motion vector filter: pipelined radius and slope test.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------------------
//   in      | input     | in_valid / in_ready     | in_start_x, in_start_y, in_end_x, in_end_y
//   out     | output    | out_valid / out_ready   | out_keep
//   cfg     | input     | cfg_psel/penable/pready | cfg_paddr, cfg_pwdata, cfg_prdata
//
// Throughput is one item per cycle while out_ready is high. The square root pipeline,
// which produces one root bit per stage, sets the depth; the root is DW + 1 bits wide, where
// DW is the larger of COORD_INT_BITS and 12 (12 at Q12.4).
// rst_n is synchronous: it clears all stage valid bits and loads register defaults.
// Each stage holds its item while the stage after it is full and stalled, so bubbles
// collapse and a stalled output does not stop intake until the pipeline is full.

module radial_motion_vector_filter #(
  parameter int COORD_INT_BITS  = rmvf_pkg::COORD_INT_BITS_DEF,
  parameter int COORD_FRAC_BITS = rmvf_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  // input channel
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0]  in_start_x,
  input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0]  in_start_y,
  input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0]  in_end_x,
  input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0]  in_end_y,
  // result channel
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic                                       out_keep,
  // configuration port
  input  logic                                       cfg_psel,
  input  logic                                       cfg_penable,
  input  logic                                       cfg_pwrite,
  input  logic [rmvf_pkg::CFG_ADDR_W-1:0]            cfg_paddr,
  input  logic [rmvf_pkg::CFG_DATA_W-1:0]            cfg_pwdata,
  output logic [rmvf_pkg::CFG_DATA_W-1:0]            cfg_prdata,
  output logic                                       cfg_pready
);

  localparam int CW   = COORD_INT_BITS + COORD_FRAC_BITS;
  localparam int DW   = (COORD_INT_BITS > rmvf_pkg::CENTER_W) ? COORD_INT_BITS
                                                              : rmvf_pkg::CENTER_W;
  localparam int RW   = DW + 1;          // root width
  localparam int SW   = 2 * RW;          // radicand / remainder width
  localparam int PW   = rmvf_pkg::SLOPE_W + CW;
  localparam int NST  = RW + 4;          // A, B, C, RW root stages, output
  localparam int LAST = NST - 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [rmvf_pkg::CENTER_W-1:0]  center_x_r;
  logic [rmvf_pkg::CENTER_W-1:0]  center_y_r;
  logic [rmvf_pkg::SLOPE_W-1:0]   min_slope_r;
  logic                           cfg_we;
  logic [rmvf_pkg::REG_IDX_W-1:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[rmvf_pkg::CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r  <= rmvf_pkg::CENTER_X_RST;
      center_y_r  <= rmvf_pkg::CENTER_Y_RST;
      min_slope_r <= rmvf_pkg::MIN_SLOPE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        rmvf_pkg::REG_CENTER_X:  center_x_r  <= cfg_pwdata[rmvf_pkg::CENTER_W-1:0];
        rmvf_pkg::REG_CENTER_Y:  center_y_r  <= cfg_pwdata[rmvf_pkg::CENTER_W-1:0];
        rmvf_pkg::REG_MIN_SLOPE: min_slope_r <= cfg_pwdata[rmvf_pkg::SLOPE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (cfg_idx)
      rmvf_pkg::REG_CENTER_X:  cfg_prdata = rmvf_pkg::CFG_DATA_W'(center_x_r);
      rmvf_pkg::REG_CENTER_Y:  cfg_prdata = rmvf_pkg::CFG_DATA_W'(center_y_r);
      rmvf_pkg::REG_MIN_SLOPE: cfg_prdata = rmvf_pkg::CFG_DATA_W'(min_slope_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage valid bits and load enables; a stage loads when empty or draining
  // ---------------------------------------------------------------------------
  logic [NST-1:0] v_r;
  logic [NST-1:0] ld;

  always_comb begin
    ld[LAST] = !v_r[LAST] || out_ready;
    for (int j = LAST - 1; j >= 0; j--) begin
      ld[j] = !v_r[j] || ld[j+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) v_r[0] <= in_valid;
      for (int j = 1; j < NST; j++) begin
        if (ld[j]) v_r[j] <= v_r[j-1];
      end
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = v_r[LAST];

  // ---------------------------------------------------------------------------
  // Stage A: whole-pixel offsets from the center, coordinate differences
  // ---------------------------------------------------------------------------
  logic [DW-1:0] cx, cy, sx_i, sy_i, ex_i, ey_i;
  logic [DW-1:0] sdx_nxt, sdy_nxt, edx_nxt, edy_nxt;
  logic [CW-1:0] adx_nxt, ady_nxt;
  logic [DW-1:0] sdx_r, sdy_r, edx_r, edy_r;
  logic [CW-1:0] adx_a_r, ady_a_r;

  assign cx   = DW'(center_x_r);
  assign cy   = DW'(center_y_r);
  assign sx_i = DW'(in_start_x[CW-1:COORD_FRAC_BITS]);
  assign sy_i = DW'(in_start_y[CW-1:COORD_FRAC_BITS]);
  assign ex_i = DW'(in_end_x[CW-1:COORD_FRAC_BITS]);
  assign ey_i = DW'(in_end_y[CW-1:COORD_FRAC_BITS]);

  assign sdx_nxt = (sx_i >= cx) ? sx_i - cx : cx - sx_i;
  assign sdy_nxt = (sy_i >= cy) ? sy_i - cy : cy - sy_i;
  assign edx_nxt = (ex_i >= cx) ? ex_i - cx : cx - ex_i;
  assign edy_nxt = (ey_i >= cy) ? ey_i - cy : cy - ey_i;
  assign adx_nxt = (in_end_x >= in_start_x) ? in_end_x - in_start_x : in_start_x - in_end_x;
  assign ady_nxt = (in_end_y >= in_start_y) ? in_end_y - in_start_y : in_start_y - in_end_y;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      sdx_r   <= sdx_nxt;
      sdy_r   <= sdy_nxt;
      edx_r   <= edx_nxt;
      edy_r   <= edy_nxt;
      adx_a_r <= adx_nxt;
      ady_a_r <= ady_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: squares and the slope threshold product
  // ---------------------------------------------------------------------------
  logic [2*DW-1:0] ssx_nxt, ssy_nxt, esx_nxt, esy_nxt;
  logic [2*DW-1:0] ssx_r, ssy_r, esx_r, esy_r;
  logic [PW-1:0]   prod_nxt, prod_r;
  logic [CW-1:0]   ady_b_r;

  assign ssx_nxt  = {{DW{1'b0}}, sdx_r} * {{DW{1'b0}}, sdx_r};
  assign ssy_nxt  = {{DW{1'b0}}, sdy_r} * {{DW{1'b0}}, sdy_r};
  assign esx_nxt  = {{DW{1'b0}}, edx_r} * {{DW{1'b0}}, edx_r};
  assign esy_nxt  = {{DW{1'b0}}, edy_r} * {{DW{1'b0}}, edy_r};
  assign prod_nxt = PW'(min_slope_r) * PW'(adx_a_r);

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      ssx_r   <= ssx_nxt;
      ssy_r   <= ssy_nxt;
      esx_r   <= esx_nxt;
      esy_r   <= esy_nxt;
      prod_r  <= prod_nxt;
      ady_b_r <= ady_a_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: squared radii and steepness test (|dy| * 2^16 > slope * |dx|)
  // Root stage k holds rem/root after deciding root bit RW-k; index 0 is stage C.
  // ---------------------------------------------------------------------------
  logic [SW-1:0] rem_s_r  [0:RW];
  logic [SW-1:0] rem_e_r  [0:RW];
  logic [RW-1:0] root_s_r [0:RW];
  logic [RW-1:0] root_e_r [0:RW];
  logic          steep_r  [0:RW];
  logic          steep_nxt;

  assign steep_nxt = {ady_b_r, {rmvf_pkg::SLOPE_W{1'b0}}} > prod_r;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      rem_s_r[0]  <= SW'(ssx_r) + SW'(ssy_r);
      rem_e_r[0]  <= SW'(esx_r) + SW'(esy_r);
      root_s_r[0] <= '0;
      root_e_r[0] <= '0;
      steep_r[0]  <= steep_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Root stages: restoring square root, one result bit per stage, MSB first
  // ---------------------------------------------------------------------------
  for (genvar k = 1; k <= RW; k++) begin : g_root
    localparam int BI = RW - k;
    logic [SW-1:0] trial_s, trial_e;
    logic [SW-1:0] rem_s_nxt, rem_e_nxt;
    logic [RW-1:0] root_s_nxt, root_e_nxt;

    assign trial_s = (SW'(root_s_r[k-1]) << (BI + 1)) | (SW'(1) << (2 * BI));
    assign trial_e = (SW'(root_e_r[k-1]) << (BI + 1)) | (SW'(1) << (2 * BI));

    always_comb begin
      if (rem_s_r[k-1] >= trial_s) begin
        rem_s_nxt  = rem_s_r[k-1] - trial_s;
        root_s_nxt = root_s_r[k-1] | (RW'(1) << BI);
      end else begin
        rem_s_nxt  = rem_s_r[k-1];
        root_s_nxt = root_s_r[k-1];
      end
      if (rem_e_r[k-1] >= trial_e) begin
        rem_e_nxt  = rem_e_r[k-1] - trial_e;
        root_e_nxt = root_e_r[k-1] | (RW'(1) << BI);
      end else begin
        rem_e_nxt  = rem_e_r[k-1];
        root_e_nxt = root_e_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ld[2+k]) begin
        rem_s_r[k]  <= rem_s_nxt;
        rem_e_r[k]  <= rem_e_nxt;
        root_s_r[k] <= root_s_nxt;
        root_e_r[k] <= root_e_nxt;
        steep_r[k]  <= steep_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: end strictly farther out and steep enough
  // ---------------------------------------------------------------------------
  logic keep_nxt, keep_r;

  assign keep_nxt = (root_s_r[RW] < root_e_r[RW]) && steep_r[RW];

  always_ff @(posedge clk) begin
    if (ld[LAST]) keep_r <= keep_nxt;
  end

  assign out_keep = keep_r;

`ifndef SYNTHESIS
  // Final remainder stays within 2*root, so each root is the floor square root
  a_root_floor_s: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2+RW] |-> (rem_s_r[RW] <= {root_s_r[RW], 1'b0}))
    else $error("start radius root not floored");

  a_root_floor_e: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2+RW] |-> (rem_e_r[RW] <= {root_e_r[RW], 1'b0}))
    else $error("end radius root not floored");

  // An empty output stage means the whole chain can take an item
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[LAST] |-> in_ready)
    else $error("intake blocked with empty output stage");

  // A blocked stage keeps its item
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[2] && !ld[3]) |=> (v_r[2] && $stable(steep_r[0]) && $stable(rem_s_r[0])))
    else $error("stalled stage lost its item");

  // A write to center_x lands in the register
  a_cfg_center_x: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_idx == rmvf_pkg::REG_CENTER_X)
      |=> (center_x_r == $past(cfg_pwdata[rmvf_pkg::CENTER_W-1:0])))
    else $error("center_x write not taken");
`endif

endmodule
